/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; each use sits inside a module that has clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache simulator.
// Depends on nothing; every module of the block but salc_ram imports it.
package salc_pkg;

  localparam int MAX_SETS    = 64;
  localparam int MAX_WAYS    = 8;
  localparam int SET_W       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W        = $clog2(MAX_WAYS + 1);
  localparam int ADDR_W      = 64;
  localparam int TAG_W       = 64;
  localparam int STAMP_W     = 32;
  localparam int CNT_W       = 32;
  localparam int SETB_W      = 3;
  localparam int BLKB_W      = 6;
  localparam int WAYS_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_W       = MAX_WAYS * (1 + TAG_W + STAMP_W);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       hits_added;
    logic             missed;
    logic             evicted;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } out_item_t;

  // Decoded access as it waits between front and back.
  typedef struct packed {
    logic             is_fetch;
    logic             is_modify;
    logic [TAG_W-1:0] blk;
    logic [SET_W-1:0] set;
  } job_t;

  // One set of the tag store: all ways side by side.
  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  typedef enum logic {
    BK_IDLE,
    BK_UPDATE
  } back_state_t;

endpackage

/* hdl/set_assoc_lru_cache_sim_top.sv */
// Set-associative LRU cache simulator: config registers, front, queue, back.
// Depends on salc_pkg, salc_front, salc_fifo and salc_back.
//
// Each access transfer yields exactly one result transfer, in order. A load,
// store or modify goes through BK_IDLE, which reads the whole set (all ways'
// valid bits, tags and timestamps) from the tag RAM, then BK_UPDATE, which
// compares, picks the hit or fill way and writes the set back once the result
// register is free; no new access is taken before that write. An instruction
// fetch only reports the current totals. A two-entry queue of decoded
// accesses sits between front and back, and a result register sits at the
// output, so input transfers keep going while a result waits. Sets are
// tracked with one flag each, so there is no clearing pass after reset.
// Write set_bits, block_bits and ways only while no access is in flight.
module set_assoc_lru_cache_sim_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  salc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output salc_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import salc_pkg::*;

  logic [SETB_W-1:0] set_bits_r;
  logic [BLKB_W-1:0] block_bits_r;
  logic [WAYS_W-1:0] ways_r;

  logic q_full, push, pop, head_valid;
  job_t push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= WAYS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SETB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BLKB_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[WAYS_W-1:0];
        default:        ways_r       <= ways_r;
      endcase
    end
  end

  salc_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .set_bits  (set_bits_r),
    .block_bits(block_bits_r),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  salc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  salc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ways      (ways_r),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* hdl/salc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* hdl/salc_front.sv */
// Front end: accepts accesses, splits the address into block address and set.
// Depends on salc_pkg.
module salc_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  salc_pkg::in_item_t           in_item,
  input  logic [salc_pkg::SETB_W-1:0]  set_bits,
  input  logic [salc_pkg::BLKB_W-1:0]  block_bits,
  input  logic                         q_full,
  output logic                         push,
  output salc_pkg::job_t               push_job
);
  import salc_pkg::*;

  logic [TAG_W-1:0] blk;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign blk      = in_item.address >> block_bits;

  always_comb begin
    push_job           = '0;
    push_job.is_fetch  = (in_item.op == OP_IFETCH);
    push_job.is_modify = (in_item.op == OP_MODIFY);
    push_job.blk       = blk;
    // Low set_bits of the block address, folded onto the physical sets.
    for (int j = 0; j < SET_W; j++) begin
      push_job.set[j] = blk[j] && (32'(j) < 32'(set_bits));
    end
  end

endmodule

/* hdl/salc_fifo.sv */
// Short queue of decoded accesses between front and back.
// Depends on salc_pkg.
module salc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  salc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output salc_pkg::job_t head_job
);
  import salc_pkg::*;

  job_t            q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QC_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/salc_back.sv */
// Back end: reads a set from the tag RAM, resolves hit or fill, writes it back
// and keeps time and totals. Depends on salc_pkg and salc_ram.
module salc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [salc_pkg::WAYS_W-1:0] ways,
  input  logic                        head_valid,
  input  salc_pkg::job_t              head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output salc_pkg::out_item_t         out_item
);
  import salc_pkg::*;

  back_state_t        state_r, state_nxt;
  job_t               job_r;
  logic [MAX_SETS-1:0] row_init_r;
  logic [STAMP_W-1:0] time_r;
  logic [CNT_W-1:0]   hit_total_r, miss_total_r, evict_total_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               slot_free;
  logic               rd_issue, fetch_commit, upd_commit;
  logic [ROW_W-1:0]   rd_bits;
  row_t               cur_row, new_row;
  logic [NW_W-1:0]    nw;
  logic [STAMP_W-1:0] time_nxt;
  logic               hit, have_empty, have_valid;
  logic [WAY_W-1:0]   hit_way, empty_way, victim_way, fill_way;
  logic [STAMP_W-1:0] best_stamp;
  logic [1:0]         added;
  out_item_t          upd_item, fetch_item;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (upd_commit),
    .waddr(job_r.set),
    .wdata(ROW_W'(new_row)),
    .re   (rd_issue),
    .raddr(head_job.set),
    .rdata(rd_bits)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && !head_job.is_fetch) begin
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop          = 1'b0;
    rd_issue     = 1'b0;
    fetch_commit = 1'b0;
    upd_commit   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          if (head_job.is_fetch) begin
            pop          = slot_free;
            fetch_commit = slot_free;
          end else begin
            pop      = 1'b1;
            rd_issue = 1'b1;
          end
        end
      end
      BK_UPDATE: begin
        upd_commit = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Lookup and replacement
  always_comb begin
    if (ways == '0) begin
      nw = NW_W'(1);
    end else if (32'(ways) > 32'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways);
    end

    // A set never written reads as all lines empty.
    cur_row  = row_init_r[job_r.set] ? row_t'(rd_bits) : '0;
    time_nxt = time_r + 1'b1;

    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    have_valid = 1'b0;
    victim_way = '0;
    best_stamp = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (32'(i) < 32'(nw)) begin
        if (!hit && cur_row.valid[i] && cur_row.tag[i] == job_r.blk) begin
          hit     = 1'b1;
          hit_way = WAY_W'(i);
        end
        // Highest empty way wins; oldest valid way, lowest index on a tie.
        if (!cur_row.valid[i]) begin
          have_empty = 1'b1;
          empty_way  = WAY_W'(i);
        end else if (!have_valid || cur_row.stamp[i] < best_stamp) begin
          have_valid = 1'b1;
          victim_way = WAY_W'(i);
          best_stamp = cur_row.stamp[i];
        end
      end
    end

    fill_way = have_empty ? empty_way : victim_way;
    new_row  = cur_row;
    if (hit) begin
      new_row.stamp[hit_way] = time_nxt;
    end else begin
      new_row.valid[fill_way] = 1'b1;
      new_row.tag[fill_way]   = job_r.blk;
      new_row.stamp[fill_way] = time_nxt;
    end

    added = {1'b0, hit} + {1'b0, job_r.is_modify};

    upd_item.hits_added      = added;
    upd_item.missed          = !hit;
    upd_item.evicted         = !hit && !have_empty;
    upd_item.total_hits      = hit_total_r + CNT_W'(added);
    upd_item.total_misses    = miss_total_r + CNT_W'(!hit);
    upd_item.total_evictions = evict_total_r + CNT_W'(!hit && !have_empty);

    fetch_item.hits_added      = '0;
    fetch_item.missed          = 1'b0;
    fetch_item.evicted         = 1'b0;
    fetch_item.total_hits      = hit_total_r;
    fetch_item.total_misses    = miss_total_r;
    fetch_item.total_evictions = evict_total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      row_init_r    <= '0;
      time_r        <= '0;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_commit) begin
        row_init_r[job_r.set] <= 1'b1;
        time_r                <= time_nxt;
        hit_total_r           <= upd_item.total_hits;
        miss_total_r          <= upd_item.total_misses;
        evict_total_r         <= upd_item.total_evictions;
      end
      if (upd_commit || fetch_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      job_r <= head_job;
    end
    if (upd_commit) begin
      out_item_r <= upd_item;
    end else if (fetch_commit) begin
      out_item_r <= fetch_item;
    end
  end

endmodule

/* hdl/salc_checker.sv */
// Port-level checks on the result stream, bound onto the top level.
// Depends on salc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module salc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input salc_pkg::out_item_t out_item
);
  import salc_pkg::*;

  // Stalled result holds.
  `SALC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)), "result changed while stalled")

  // Back-to-back results: totals advance by exactly what the later one adds.
  `SALC_ASSERT(a_hit_step, (out_valid && out_ready ##1 out_valid) |-> (out_item.total_hits == $past(out_item.total_hits) + CNT_W'(out_item.hits_added)), "hit total out of step")

  `SALC_ASSERT(a_miss_step, (out_valid && out_ready ##1 out_valid) |-> (out_item.total_misses == $past(out_item.total_misses) + CNT_W'(out_item.missed)), "miss total out of step")

  `SALC_ASSERT(a_evict_step, (out_valid && out_ready ##1 out_valid) |-> (out_item.total_evictions == $past(out_item.total_evictions) + CNT_W'(out_item.evicted)), "eviction total out of step")

endmodule

bind set_assoc_lru_cache_sim_top salc_checker u_checker (.*);
